[hdl/kpsa_pkg.sv]
`default_nettype none

package kpsa_pkg;

    localparam int NUM_KEYS      = 13;
    localparam int NUM_DIRS      = 8;
    localparam int NUM_ROW2_KEYS = 4;
    localparam int ROW_W         = 4;
    localparam int KEY_W         = 4;
    localparam int CNT_W         = 11;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;
    localparam int QUEUE_DEPTH   = 2;

    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [NUM_KEYS-1:0] t_key_mask;
    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [ROW_W-1:0]    t_row;

    localparam t_count CNT_MAX        = {CNT_W{1'b1}};
    localparam t_count FIRST_CNT_RST  = 11'd10;
    localparam t_count REPEAT_CNT_RST = 11'd250;
    localparam t_count WRAP_CNT_RST   = 11'd351;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_FIRST  = 2'd0;
    localparam logic [1:0] REG_REPEAT = 2'd1;
    localparam logic [1:0] REG_WRAP   = 2'd2;

    // Joystick row codes in key order: up, down, left, right,
    // up-left, up-right, down-left, down-right.
    localparam t_row DIR_CODES [NUM_DIRS] = '{
        4'h6, 4'h9, 4'hC, 4'h3, 4'hE, 4'h7, 4'hD, 4'hB
    };

    typedef struct packed {
        t_count first_cnt;
        t_count repeat_cnt;
        t_count wrap_cnt;
    } t_cfg;

endpackage

`default_nettype wire

[hdl/keypad_scan_autorepeat_unit.sv]
`default_nettype none

// Keypad scanner with per-key hold counting and auto-repeat. Each transfer
// on the input channel is one scan tick; it is decoded into thirteen key
// states, all hold counters update together, and the keys that fire are
// queued as one mask. The output side then sends one transfer per fired
// key, lowest key code first, with o_last_event set on the final one of
// the tick. A tick is taken in the cycle it arrives while the two-entry
// event queue has room, and the output stage delivers one event a cycle
// while the receiver is ready; a tick fires at most six events. The
// thresholds are set over the APB port: first_count at 0x0,
// repeat_count at 0x4, wrap_count at 0x8; write them only while the
// block is idle.
module keypad_scan_autorepeat_unit
    import kpsa_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [ROW_W-1:0]      i_row1_code,
    input  wire logic [ROW_W-1:0]      i_row2_code,
    input  wire logic [ROW_W-1:0]      i_row3_code,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [KEY_W-1:0]           o_key_code,
    output logic                       o_last_event,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    t_cfg      r_cfg;
    logic      cfg_write;
    logic      q_push;
    t_key_mask q_push_mask;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    t_key_mask q_mask;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_cnt  <= FIRST_CNT_RST;
            r_cfg.repeat_cnt <= REPEAT_CNT_RST;
            r_cfg.wrap_cnt   <= WRAP_CNT_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_FIRST:  r_cfg.first_cnt  <= pwdata[CNT_W-1:0];
                REG_REPEAT: r_cfg.repeat_cnt <= pwdata[CNT_W-1:0];
                REG_WRAP:   r_cfg.wrap_cnt   <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FIRST:  prdata = APB_DATA_W'(r_cfg.first_cnt);
            REG_REPEAT: prdata = APB_DATA_W'(r_cfg.repeat_cnt);
            REG_WRAP:   prdata = APB_DATA_W'(r_cfg.wrap_cnt);
            default:    prdata = '0;
        endcase
    end

    kpsa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_row1_code (i_row1_code),
        .i_row2_code (i_row2_code),
        .i_row3_code (i_row3_code),
        .i_cfg       (r_cfg),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_mask (q_push_mask)
    );

    kpsa_fifo #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_push_mask),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_mask)
    );

    kpsa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_mask     (q_mask),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_key_code   (o_key_code),
        .o_last_event (o_last_event)
    );

endmodule

`default_nettype wire

[hdl/kpsa_front.sv]
`default_nettype none

module kpsa_front
    import kpsa_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_row      i_row1_code,
    input  wire t_row      i_row2_code,
    input  wire t_row      i_row3_code,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_q_full,
    output logic           o_push,
    output t_key_mask      o_push_mask
);

    t_count    r_cnt [NUM_KEYS];
    t_count    n_cnt [NUM_KEYS];
    t_key_mask held;
    t_key_mask events;
    logic      accept;

    always_comb begin
        for (int k = 0; k < NUM_DIRS; k++) begin
            held[k] = (i_row1_code == DIR_CODES[k]);
        end
        for (int k = 0; k < NUM_ROW2_KEYS; k++) begin
            held[NUM_DIRS + k] = !i_row2_code[k];
        end
        held[NUM_KEYS-1] = !i_row3_code[0];
    end

    // Every key updates in parallel: zero when released, else increment with
    // saturation, reload on the wrap value, compare against both thresholds.
    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (!held[k]) begin
                n_cnt[k] = '0;
            end else if (r_cnt[k] == CNT_MAX) begin
                n_cnt[k] = r_cnt[k];
            end else begin
                n_cnt[k] = r_cnt[k] + t_count'(1);
            end
            if (held[k] && (n_cnt[k] == i_cfg.wrap_cnt)) begin
                n_cnt[k] = i_cfg.repeat_cnt;
            end
            events[k] = held[k] && ((n_cnt[k] == i_cfg.first_cnt) ||
                                    (n_cnt[k] == i_cfg.repeat_cnt));
        end
    end

    assign accept      = i_valid && !i_q_full;
    assign o_ready     = !i_q_full;
    assign o_push      = accept && (events != '0);
    assign o_push_mask = events;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (accept) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

    // The joystick decode can never report two directions at once.
    a_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> $onehot0(o_push_mask[NUM_DIRS-1:0]))
        else $error("more than one joystick direction fired in one tick");

endmodule

`default_nettype wire

[hdl/kpsa_fifo.sv]
`default_nettype none

module kpsa_fifo
    import kpsa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_key_mask i_data,
    output logic           o_full,
    input  wire logic      i_pop,
    output logic           o_valid,
    output t_key_mask      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    t_key_mask           r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W_Q-1:0]  r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W_Q'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W_Q'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W_Q'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("event queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("event queue read while empty");

endmodule

`default_nettype wire

[hdl/kpsa_back.sv]
`default_nettype none

module kpsa_back
    import kpsa_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_q_valid,
    input  wire t_key_mask i_q_mask,
    output logic           o_pop,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_key           o_key_code,
    output logic           o_last_event
);

    t_key_mask r_mask;
    t_key_mask n_mask;
    logic      r_out_valid;
    logic      n_out_valid;
    t_key      r_key;
    logic      r_last;
    t_key_mask low_bit;
    t_key_mask rest;
    t_key      low_idx;
    logic      out_free;
    logic      take;

    // Lowest pending key first, so events leave in key order.
    always_comb begin
        low_bit = r_mask & (~r_mask + t_key_mask'(1));
        rest    = r_mask & ~low_bit;
        low_idx = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (low_bit[k]) begin
                low_idx = low_idx | t_key'(k);
            end
        end
    end

    always_comb begin
        out_free = !r_out_valid || i_ready;
        take     = out_free && (r_mask != '0);
        n_mask   = take ? rest : r_mask;
        o_pop    = (n_mask == '0) && i_q_valid;
        if (o_pop) begin
            n_mask = i_q_mask;
        end
        if (take) begin
            n_out_valid = 1'b1;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_key  <= low_idx;
            r_last <= (rest == '0);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_key_code   = r_key;
    assign o_last_event = r_last;

    // Only ticks that raised at least one event are queued.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_q_mask != '0))
        else $error("empty event mask taken from the queue");

    // An event that is not the last of its tick leaves more of it pending.
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (r_mask != '0))
        else $error("tick ended without a marked last event");

endmodule

`default_nettype wire

[verif/keypad_scan_autorepeat_unit_tb.sv]
`default_nettype none

module keypad_scan_autorepeat_unit_tb;
    import kpsa_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Joystick row codes in key-code order.
    localparam t_row JOY_CODES [NUM_DIRS] = '{
        4'h6, 4'h9, 4'hC, 4'h3, 4'hE, 4'h7, 4'hD, 4'hB
    };

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_TOGGLE,
        RDY_SPARSE
    } t_rdy_mode;

    typedef struct {
        t_row row1;
        t_row row2;
        t_row row3;
        bit   hold_off;
    } t_scan;

    typedef struct {
        t_key code;
        logic last;
    } t_key_event;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  o_ready;
    logic [ROW_W-1:0]      i_row1_code  = '1;
    logic [ROW_W-1:0]      i_row2_code  = '1;
    logic [ROW_W-1:0]      i_row3_code  = '1;
    logic                  o_valid;
    logic                  i_ready      = 1'b0;
    logic [KEY_W-1:0]      o_key_code;
    logic                  o_last_event;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Scan ticks waiting to be driven and key events still to come out.
    t_scan      tick_q[$];
    t_key_event pending_events[$];

    // Shadow of the hold counters and thresholds.
    t_count hold_cnt [NUM_KEYS];
    t_count first_thr  = FIRST_CNT_RST;
    t_count repeat_thr = REPEAT_CNT_RST;
    t_count wrap_thr   = WRAP_CNT_RST;

    int        err_count   = 0;
    int        idle_cycles = 0;
    bit        tick_taken  = 1'b0;
    int        burst_left  = 0;
    int        gap_left    = 0;
    t_rdy_mode rdy_mode    = RDY_ALWAYS;
    int        rdy_left    = 0;

    keypad_scan_autorepeat_unit dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            hold_cnt[k] = '0;
        end
    end

    function automatic void flag_error(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    // Advances every hold counter by one scan tick and queues the events it fires.
    function automatic void scan_tick(t_row r1, t_row r2, t_row r3);
        logic       held;
        t_count     c;
        t_key       fired[$];
        t_key_event ev;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (k < NUM_DIRS) begin
                held = (r1 == JOY_CODES[k]);
            end else if (k < NUM_DIRS + NUM_ROW2_KEYS) begin
                held = !r2[k - NUM_DIRS];
            end else begin
                held = !r3[0];
            end
            if (!held) begin
                hold_cnt[k] = '0;
            end else begin
                c = hold_cnt[k];
                if (c != CNT_MAX) begin
                    c = c + 1'b1;
                end
                if (c == wrap_thr) begin
                    c = repeat_thr;
                end
                hold_cnt[k] = c;
                if (c == first_thr || c == repeat_thr) begin
                    fired.push_back(t_key'(k));
                end
            end
        end
        foreach (fired[i]) begin
            ev.code = fired[i];
            ev.last = (i == fired.size() - 1);
            pending_events.push_back(ev);
        end
    endfunction

    function automatic void add_tick(t_row r1, t_row r2, t_row r3, bit hold_off);
        t_scan s;
        s.row1     = r1;
        s.row2     = r2;
        s.row3     = r3;
        s.hold_off = hold_off;
        tick_q.push_back(s);
    endfunction

    // Runs of a steady key pattern, with the odd disturbed tick thrown in.
    task automatic queue_hold_runs(input int n_items, input int max_run);
        t_row r1, r2, r3;
        t_row n1, n2, n3;
        int   run;
        int   left;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(0, 3) != 0) begin
                r1 = JOY_CODES[$urandom_range(0, NUM_DIRS - 1)];
            end else begin
                r1 = t_row'($urandom_range(0, 15));
            end
            r2  = t_row'($urandom_range(0, 15));
            r3  = t_row'($urandom_range(0, 15));
            run = $urandom_range(1, max_run);
            if (run > left) begin
                run = left;
            end
            for (int i = 0; i < run; i++) begin
                n1 = r1;
                n2 = r2;
                n3 = r3;
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 2))
                        0: n1 = t_row'($urandom_range(0, 15));
                        1: n2 = t_row'($urandom_range(0, 15));
                        default: n3 = t_row'($urandom_range(0, 15));
                    endcase
                end
                add_tick(n1, n2, n3, $urandom_range(0, 39) == 0);
            end
            left -= run;
        end
    endtask

    // Key 8 stays held throughout while everything else varies.
    task automatic queue_long_hold(input int n);
        t_row r2;
        for (int i = 0; i < n; i++) begin
            r2    = t_row'($urandom_range(0, 15));
            r2[0] = 1'b0;
            add_tick(t_row'($urandom_range(0, 15)), r2, t_row'($urandom_range(0, 15)), 1'b0);
        end
    endtask

    task automatic wait_idle();
        while (tick_q.size() != 0 || i_valid || pending_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input t_count val);
        logic [APB_DATA_W-1:0] wd;
        wd            = $urandom;
        wd[CNT_W-1:0] = val;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wd;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FIRST:  first_thr  = val;
            REG_REPEAT: repeat_thr = val;
            REG_WRAP:   wrap_thr   = val;
            default: ;
        endcase
    endtask

    task automatic apb_check(input logic [1:0] idx, input t_count want);
        t_count got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata[CNT_W-1:0];
        if (got !== want) begin
            flag_error($sformatf("register %0d reads %0d, expected %0d", idx, got, want));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_thresholds();
        apb_check(REG_FIRST, first_thr);
        apb_check(REG_REPEAT, repeat_thr);
        apb_check(REG_WRAP, wrap_thr);
    endtask

    task automatic set_thresholds(input t_count f, input t_count r, input t_count w);
        apb_write(REG_FIRST, f);
        apb_write(REG_REPEAT, r);
        apb_write(REG_WRAP, w);
        check_thresholds();
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin : tick_driver
        t_scan s;
        logic  drive;
        drive = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !tick_taken) begin
                drive = 1'b1;
            end else if (gap_left != 0) begin
                gap_left--;
            end else if (tick_q.size() != 0
                         && !(tick_q[0].hold_off && pending_events.size() != 0)) begin
                s     = tick_q.pop_front();
                drive = 1'b1;
                i_row1_code <= s.row1;
                i_row2_code <= s.row2;
                i_row3_code <= s.row3;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 32);
                end
                burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 20)
                                                           : $urandom_range(0, 3);
                end
            end
        end
        i_valid <= drive;
    end

    // Receiver: stall behaviour switches between a few patterns.
    always @(negedge i_clk) begin : ready_driver
        if (rdy_left == 0) begin
            rdy_mode = t_rdy_mode'($urandom_range(0, 3));
            rdy_left = $urandom_range(20, 80);
        end
        rdy_left--;
        case (rdy_mode)
            RDY_ALWAYS: i_ready <= 1'b1;
            RDY_RANDOM: i_ready <= 1'($urandom_range(0, 1));
            RDY_TOGGLE: i_ready <= ~i_ready;
            default:    i_ready <= (rdy_left % 4 == 0);
        endcase
    end

    always @(posedge i_clk) begin : event_monitor
        t_key_event want;
        bit         ev_taken;
        if (i_rst_n) begin
            tick_taken = i_valid && o_ready;
            ev_taken   = o_valid && i_ready;
            // Predict the tick first, then check the event taken in this cycle.
            if (tick_taken) begin
                scan_tick(i_row1_code, i_row2_code, i_row3_code);
            end
            if (ev_taken) begin
                if (pending_events.size() == 0) begin
                    flag_error($sformatf("unexpected event: key %0d last %0b",
                                         o_key_code, o_last_event));
                end else begin
                    want = pending_events.pop_front();
                    if (o_key_code !== want.code || o_last_event !== want.last) begin
                        flag_error($sformatf(
                            "event mismatch: key %0d last %0b, expected key %0d last %0b",
                            o_key_code, o_last_event, want.code, want.last));
                    end
                end
            end
            if (tick_taken || ev_taken) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        check_thresholds();

        // All six keys held from reset fire together on the first threshold,
        // then every joystick code, used or not, and every row nibble.
        for (int i = 0; i < 10; i++) begin
            add_tick(JOY_CODES[0], 4'h0, 4'hE, 1'b0);
        end
        for (int i = 0; i < 16; i++) begin
            add_tick(t_row'(i), t_row'(i), t_row'(15 - i), 1'b0);
        end
        wait_idle();

        set_thresholds(11'd3, 11'd7, 11'd12);
        queue_hold_runs(120, 16);
        wait_idle();

        // Equal thresholds: a held key fires every tick, but only once.
        set_thresholds(11'd1, 11'd1, 11'd2);
        apb_write(REG_UNUSED, t_count'($urandom));
        check_thresholds();
        for (int i = 0; i < 3; i++) begin
            add_tick(JOY_CODES[$urandom_range(0, NUM_DIRS - 1)], 4'h0, 4'h0, 1'b0);
        end
        queue_hold_runs(80, 6);
        wait_idle();

        set_thresholds(11'd0, 11'd0, 11'd0);
        queue_hold_runs(40, 20);
        wait_idle();

        set_thresholds(11'd2, 11'd5, 11'd9);
        queue_hold_runs(100, 14);
        wait_idle();

        // Key 8 is reloaded just below the ceiling, climbs to it and sits
        // there, since the wrap value is never met again.
        set_thresholds(CNT_MAX, 11'd2040, 11'd5);
        queue_long_hold(30);
        wait_idle();

        // With the wrap value at the ceiling the saturated counter reloads.
        apb_write(REG_WRAP, CNT_MAX);
        check_thresholds();
        queue_long_hold(20);
        queue_hold_runs(40, 10);
        wait_idle();

        if (pending_events.size() != 0) begin
            flag_error($sformatf("%0d key events never arrived", pending_events.size()));
        end
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hdl/kpsa_pkg.sv
hdl/kpsa_front.sv
hdl/kpsa_fifo.sv
hdl/kpsa_back.sv
hdl/keypad_scan_autorepeat_unit.sv
verif/keypad_scan_autorepeat_unit_tb.sv
